@@ rtl/rcw_pkg.sv @@
// Shared types, constants and the code generator step for the rolling-code receiver.
// No dependencies; every other rtl file uses this package by scoped names.
package rcw_pkg;

  localparam int WINDOW_SIZE = 251;
  localparam int CODE_W      = 23;
  localparam int TICK_W      = 24;
  localparam int RX_CODE_W   = 32;
  localparam int SHIFT_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CODE_W-1:0] SEED_RST     = 23'd425;
  localparam logic [CODE_W-1:0] MULT_RST     = 23'd107;
  localparam logic [CODE_W-1:0] INCR_RST     = 23'd11;
  localparam logic [TICK_W-1:0] INTERVAL_RST = 24'd30000;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_CODE = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } rcw_op_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_ACCEPT    = 3'd1,
    ST_REJECT    = 3'd2,
    ST_ZERO      = 3'd3,
    ST_CHALLENGE = 3'd4,
    ST_INIT      = 3'd5
  } rcw_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED     = 2'd0,
    REG_MULT     = 2'd1,
    REG_INCR     = 2'd2,
    REG_INTERVAL = 2'd3
  } rcw_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_SEARCH,
    S_ADVANCE
  } rcw_state_t;

  typedef struct packed {
    rcw_op_t                operation;
    logic [RX_CODE_W-1:0]   received_code;
  } rcw_cmd_t;

  typedef struct packed {
    rcw_status_t            status;
    logic [CODE_W-1:0]      challenge_code;
    logic [SHIFT_W-1:0]     shift_count;
  } rcw_result_t;

  typedef struct packed {
    logic [CODE_W-1:0]      seed;
    logic [CODE_W-1:0]      mult;
    logic [CODE_W-1:0]      incr;
    logic [TICK_W-1:0]      interval;
  } rcw_cfg_t;

  // shift: every cell takes its neighbor's value; rotate: tail takes the front
  typedef struct packed {
    logic                   shift;
    logic                   rotate;
    logic [CODE_W-1:0]      new_code;
  } rcw_chain_ctl_t;

  // One generator step, mod 2^23
  function automatic logic [CODE_W-1:0] lcg_step(input logic [CODE_W-1:0] mult,
                                                 input logic [CODE_W-1:0] incr,
                                                 input logic [CODE_W-1:0] s);
    logic [2*CODE_W-1:0] prod;
    prod = (2*CODE_W)'(mult) * (2*CODE_W)'(s);
    return prod[CODE_W-1:0] + incr;
  endfunction

endpackage

@@ rtl/rcw_cell.sv @@
// One window cell: a code register loaded from its neighbor on shift.
// Uses rcw_pkg for the code width.
module rcw_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [rcw_pkg::CODE_W-1:0]  d,
  output logic [rcw_pkg::CODE_W-1:0]  q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

@@ rtl/rcw_chain.sv @@
// Code window as a chain of rcw_cell, front at cell 0, newest at the tail.
// Uses rcw_pkg (chain control struct) and rcw_cell.
module rcw_chain #(
  parameter int WINDOW_SIZE = rcw_pkg::WINDOW_SIZE
) (
  input  logic                            clk,
  input  rcw_pkg::rcw_chain_ctl_t         ctl,
  output logic [rcw_pkg::CODE_W-1:0]      front
);

  logic [rcw_pkg::CODE_W-1:0] q [WINDOW_SIZE];
  logic [rcw_pkg::CODE_W-1:0] tail;

  // rotation feeds the front back in so a full pass restores the order
  assign tail  = ctl.rotate ? q[0] : ctl.new_code;
  assign front = q[0];

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    if (i == WINDOW_SIZE - 1) begin : g_tail
      rcw_cell u_cell (.clk(clk), .shift(ctl.shift), .d(tail), .q(q[i]));
    end else begin : g_mid
      rcw_cell u_cell (.clk(clk), .shift(ctl.shift), .d(q[i+1]), .q(q[i]));
    end
  end

endmodule

@@ rtl/rcw_ctrl.sv @@
// Sequencer: init fill, window search by rotation, advance, tick counting.
// Uses rcw_pkg (types, lcg_step); drives the rcw_chain control struct.
module rcw_ctrl #(
  parameter int WINDOW_SIZE = rcw_pkg::WINDOW_SIZE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  rcw_pkg::rcw_cmd_t             cmd,
  input  rcw_pkg::rcw_cfg_t             cfg,
  input  logic [rcw_pkg::CODE_W-1:0]    front,
  output rcw_pkg::rcw_chain_ctl_t       chain_ctl,
  output logic                          busy,
  output logic                          done,
  output rcw_pkg::rcw_result_t          result
);

  localparam int KW = $clog2(WINDOW_SIZE);
  localparam int CW = $clog2(WINDOW_SIZE + 2);
  localparam logic [CW-1:0] LAST = CW'(WINDOW_SIZE - 1);

  rcw_pkg::rcw_state_t                state, state_next;
  logic [CW-1:0]                      cnt, cnt_next;
  logic [KW-1:0]                      k, k_next;
  logic                               found, found_next;
  logic [rcw_pkg::CODE_W-1:0]         newest, newest_next;
  logic [rcw_pkg::CODE_W-1:0]         challenge, challenge_next;
  logic [rcw_pkg::TICK_W-1:0]         tick_count, tick_next;
  logic [rcw_pkg::RX_CODE_W-1:0]      code_reg, code_next;
  logic                               done_next;
  rcw_pkg::rcw_result_t               result_next;

  logic [rcw_pkg::CODE_W-1:0]         lcg_in, lcg_out;
  logic [rcw_pkg::TICK_W-1:0]         tick_inc;
  logic [CW-1:0]                      k_plus;
  logic                               match;

  assign lcg_in   = (state == rcw_pkg::S_IDLE) ? cfg.seed : newest;
  assign lcg_out  = rcw_pkg::lcg_step(cfg.mult, cfg.incr, lcg_in);
  assign tick_inc = tick_count + 1'b1;
  assign k_plus   = CW'(k) + 1'b1;
  // codes of 2^23 and above never match
  assign match    = (code_reg[rcw_pkg::RX_CODE_W-1:rcw_pkg::CODE_W] == '0) &&
                    (front == code_reg[rcw_pkg::CODE_W-1:0]);
  assign busy     = (state != rcw_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rcw_pkg::S_IDLE;
      cnt        <= '0;
      found      <= 1'b0;
      newest     <= '0;
      challenge  <= '0;
      tick_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      found      <= found_next;
      newest     <= newest_next;
      challenge  <= challenge_next;
      tick_count <= tick_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    code_reg <= code_next;
    result   <= result_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    k_next         = k;
    found_next     = found;
    newest_next    = newest;
    challenge_next = challenge;
    tick_next      = tick_count;
    code_next      = code_reg;
    done_next      = 1'b0;
    result_next    = result;
    result_next.shift_count = '0;
    chain_ctl.shift    = 1'b0;
    chain_ctl.rotate   = 1'b0;
    chain_ctl.new_code = lcg_out;

    case (state)
      rcw_pkg::S_IDLE: begin
        if (start) begin
          case (cmd.operation)
            rcw_pkg::OP_INIT: begin
              newest_next    = lcg_out;
              challenge_next = lcg_out;
              cnt_next       = '0;
              state_next     = rcw_pkg::S_FILL;
            end
            rcw_pkg::OP_CODE: begin
              if (cmd.received_code == '0) begin
                done_next          = 1'b1;
                result_next.status = rcw_pkg::ST_ZERO;
              end else begin
                code_next  = cmd.received_code;
                cnt_next   = '0;
                found_next = 1'b0;
                state_next = rcw_pkg::S_SEARCH;
              end
            end
            rcw_pkg::OP_TICK: begin
              done_next          = 1'b1;
              result_next.status = (tick_count == '0) ? rcw_pkg::ST_CHALLENGE
                                                      : rcw_pkg::ST_NONE;
              // interval of zero acts like one
              tick_next = (tick_inc >= cfg.interval) ? '0 : tick_inc;
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = rcw_pkg::ST_NONE;
            end
          endcase
        end
      end

      rcw_pkg::S_FILL: begin
        chain_ctl.shift = 1'b1;
        newest_next     = lcg_out;
        cnt_next        = cnt + 1'b1;
        if (cnt == LAST) begin
          done_next          = 1'b1;
          result_next.status = rcw_pkg::ST_INIT;
          state_next         = rcw_pkg::S_IDLE;
        end
      end

      rcw_pkg::S_SEARCH: begin
        chain_ctl.shift  = 1'b1;
        chain_ctl.rotate = 1'b1;
        cnt_next         = cnt + 1'b1;
        // first hit from the front wins
        if (!found && match) begin
          found_next = 1'b1;
          k_next     = cnt[KW-1:0];
        end
        if (cnt == LAST) begin
          if (found || match) begin
            cnt_next   = '0;
            state_next = rcw_pkg::S_ADVANCE;
          end else begin
            done_next          = 1'b1;
            result_next.status = rcw_pkg::ST_REJECT;
            state_next         = rcw_pkg::S_IDLE;
          end
        end
      end

      rcw_pkg::S_ADVANCE: begin
        chain_ctl.shift = 1'b1;
        newest_next     = lcg_out;
        cnt_next        = cnt + 1'b1;
        // after k+1 advances the front is the code after the accepted one
        if (cnt == k_plus) begin
          challenge_next          = front;
          done_next               = 1'b1;
          result_next.status      = rcw_pkg::ST_ACCEPT;
          result_next.shift_count = rcw_pkg::SHIFT_W'(k_plus);
          state_next              = rcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rcw_pkg::S_IDLE;
      end
    endcase

    result_next.challenge_code = challenge_next;
  end

endmodule

@@ rtl/rolling_code_window_receiver.sv @@
// Rolling-code receiver top level: config registers, sequencer and code window chain.
// Uses rcw_pkg, rcw_ctrl, rcw_chain (and through it rcw_cell).
//
//  channel | handshake                     | beat payload
//  --------+-------------------------------+----------------------------------
//  command | start, busy (taken: start&!busy) | cmd   (operation, received_code)
//  result  | done (one-cycle strobe)       | result (status, challenge_code,
//          |                               |         shift_count)
//  config  | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// Tick, no-op and zero-code commands finish without raising busy. Init keeps busy
// high while the generator fills all WINDOW_SIZE cells, one cell a cycle.
// A code search rotates the whole chain, then on a hit advances it by k+2
// generator steps. done pulses the cycle after the last busy cycle, or after
// the taken start of a command that never raises busy. Synchronous reset clears
// control state; the window itself holds garbage until the first init.
// Results cannot be held off; cfg_ready is always high.
module rolling_code_window_receiver #(
  parameter int WINDOW_SIZE = rcw_pkg::WINDOW_SIZE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rcw_pkg::rcw_cmd_t                 cmd,
  output logic                              done,
  output rcw_pkg::rcw_result_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rcw_pkg::rcw_cfg_t          cfg;
  rcw_pkg::rcw_chain_ctl_t    chain_ctl;
  logic [rcw_pkg::CODE_W-1:0] front;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed     <= rcw_pkg::SEED_RST;
      cfg.mult     <= rcw_pkg::MULT_RST;
      cfg.incr     <= rcw_pkg::INCR_RST;
      cfg.interval <= rcw_pkg::INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rcw_pkg::rcw_reg_t'(cfg_index))
        rcw_pkg::REG_SEED:     cfg.seed     <= cfg_data[rcw_pkg::CODE_W-1:0];
        rcw_pkg::REG_MULT:     cfg.mult     <= cfg_data[rcw_pkg::CODE_W-1:0];
        rcw_pkg::REG_INCR:     cfg.incr     <= cfg_data[rcw_pkg::CODE_W-1:0];
        rcw_pkg::REG_INTERVAL: cfg.interval <= cfg_data[rcw_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  rcw_ctrl #(.WINDOW_SIZE(WINDOW_SIZE)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg       (cfg),
    .front     (front),
    .chain_ctl (chain_ctl),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  rcw_chain #(.WINDOW_SIZE(WINDOW_SIZE)) u_chain (
    .clk   (clk),
    .ctl   (chain_ctl),
    .front (front)
  );

`ifndef NO_ASSERTIONS
  // a result beat only follows a taken command or ongoing work
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start || busy))
    else $error("result beat without a command in flight");

  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation == rcw_pkg::OP_CODE && cmd.received_code == '0)
      |=> (done && result.status == rcw_pkg::ST_ZERO))
    else $error("zero code not flagged in the next cycle");

  a_shift_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != rcw_pkg::ST_ACCEPT) |-> (result.shift_count == '0))
    else $error("nonzero shift count without acceptance");
`endif

endmodule
